[design/multichannel_interpolated_delay_line_defines.svh]
// Assertion macros shared by the delay line RTL.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef MULTICHANNEL_INTERPOLATED_DELAY_LINE_DEFINES_SVH
`define MULTICHANNEL_INTERPOLATED_DELAY_LINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIDL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("delay line check failed");

// The consequent must hold in the cycle after the antecedent.
`define MIDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("delay line check failed");

`endif

[design/midl_pkg.sv]
// Shared widths, defaults and register indexes for the delay line.
// No dependencies; imported by the delay line top level.
`default_nettype none

package midl_pkg;

  // Default sizing of the sample store.
  localparam int DEF_MAX_DELAY = 4096;
  localparam int DEF_CHANNELS  = 8;

  // Fixed field widths.
  localparam int SAMPLE_W    = 24;
  localparam int CHAN_W      = 4;
  localparam int DELAY_W     = 12;
  localparam int FRAC_W      = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_WHOLE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_FRACTION = CFG_INDEX_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

[design/multichannel_interpolated_delay_line.sv]
// An accepted beat passes the stage 1, stage 2, stage 3 and output registers to sample_out.
// Throughput: one beat per cycle unless result_stall or the reducer holds it; the store is one
// memory with a write port and two read ports, and the four-stage datapath runs fully pipelined.
// A delay_whole write holds inputs and config for one cycle while it is reduced modulo the depth.
// Reset (rst, synchronous, active high) clears pointers, fill state, config and valid flags;
// entries not yet written since reset read as zero through per-channel fill tracking.
`default_nettype none

`include "multichannel_interpolated_delay_line_defines.svh"

module multichannel_interpolated_delay_line #(
  parameter int MAX_DELAY = midl_pkg::DEF_MAX_DELAY,
  parameter int CHANNELS  = midl_pkg::DEF_CHANNELS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input item channel.
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic [midl_pkg::CHAN_W-1:0]        channel,
  input  wire logic signed [midl_pkg::SAMPLE_W-1:0] sample_in,
  // Result channel.
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic signed [midl_pkg::SAMPLE_W-1:0]    sample_out,
  // Configuration write channel.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [midl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [midl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import midl_pkg::*;

  localparam int PTR_W     = $clog2(MAX_DELAY);
  localparam int PW1       = PTR_W + 1;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int RED_SHIFT = DELAY_W + PTR_W;
  localparam int RECIP_W   = DELAY_W + 1;
  localparam int MUL_W     = DELAY_W + RECIP_W;
  localparam int BACK_W    = DELAY_W + PW1;
  localparam longint RECIP_VAL =
    ((longint'(1) << RED_SHIFT) + longint'(MAX_DELAY) - longint'(1)) / longint'(MAX_DELAY);
  localparam int PROD_W    = FRAC_W + 1 + SAMPLE_W + 1;
  localparam int SUM_W     = PROD_W - FRAC_W;

  // Configuration registers and the delay_whole modulo reducer.
  logic [FRAC_W-1:0]  delay_fraction;
  logic [DELAY_W-1:0] rem;
  logic [DELAY_W-1:0] whole_raw;
  logic [DELAY_W-1:0] whole_quo;
  logic               red_busy;
  logic               cfg_accept;
  logic [PTR_W-1:0]   dw;
  logic [MUL_W-1:0]   quo_prod;
  logic [BACK_W-1:0]  quo_back;

  assign cfg_ready  = !red_busy;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign dw         = PTR_W'(rem);

  // The quotient comes from a multiply by the rounded-up reciprocal of the depth.
  assign quo_prod = MUL_W'(cfg_data[DELAY_W-1:0]) * MUL_W'(RECIP_VAL);
  assign quo_back = BACK_W'(whole_quo) * BACK_W'(MAX_DELAY);

  // Config writes; a delay_whole write takes its remainder in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_fraction <= '0;
      rem            <= '0;
      whole_raw      <= '0;
      whole_quo      <= '0;
      red_busy       <= 1'b0;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        REG_DELAY_WHOLE: begin
          whole_raw <= cfg_data[DELAY_W-1:0];
          whole_quo <= DELAY_W'(quo_prod >> RED_SHIFT);
          red_busy  <= 1'b1;
        end
        REG_DELAY_FRACTION: begin
          delay_fraction <= cfg_data[FRAC_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (red_busy) begin
      rem      <= whole_raw - DELAY_W'(quo_back);
      red_busy <= 1'b0;
    end
  end

  // Pipeline flow control: each stage loads when empty or when its successor moves.
  logic v1, v2, v3;
  logic en1, en2, en3, en_o;
  logic accept;

  assign en_o       = !result_valid || !result_stall;
  assign en3        = !v3 || en_o;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1 || red_busy;
  assign accept     = item_valid && !item_stall;

  // Per-channel write pointers and wrap flags (fill tracking replaces a clear pass).
  logic [PTR_W-1:0] wp      [CHANNELS];
  logic             wrapped [CHANNELS];

  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [PTR_W-1:0]    w, w_adv, i1, i2;
  logic                wrap_adv, va, vb, fa, fb;
  logic [ADDR_W-1:0]   base, addr_w, addr_a, addr_b;

  // Pointer arithmetic and read addresses for the incoming beat.
  always_comb begin
    ch_ok    = {1'b0, channel} < (CHAN_W + 1)'(CHANNELS);
    ch_idx   = CH_IDX_W'(channel);
    w        = wp[ch_idx];
    w_adv    = (w == PTR_W'(MAX_DELAY - 1)) ? '0 : w + 1'b1;
    wrap_adv = wrapped[ch_idx] || (w_adv == '0);
    if (w_adv >= dw) begin
      i1 = PTR_W'({1'b0, w_adv} - {1'b0, dw});
    end else begin
      i1 = PTR_W'({1'b0, w_adv} + PW1'(MAX_DELAY) - {1'b0, dw});
    end
    i2     = (i1 == PTR_W'(MAX_DELAY - 1)) ? '0 : i1 + 1'b1;
    va     = wrap_adv || (i1 < w_adv);
    vb     = wrap_adv || (i2 < w_adv);
    fa     = (i1 == w);
    fb     = (i2 == w);
    base   = ADDR_W'(ch_idx) * ADDR_W'(MAX_DELAY);
    addr_w = base + ADDR_W'(w);
    addr_a = base + ADDR_W'(i1);
    addr_b = base + ADDR_W'(i2);
  end

  // Pointer update on every accepted beat of a valid channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp[c]      <= '0;
        wrapped[c] <= 1'b0;
      end
    end else if (accept && ch_ok) begin
      wp[ch_idx]      <= w_adv;
      wrapped[ch_idx] <= wrap_adv;
    end
  end

  // Sample store: one write port, two registered read ports.
  logic [SAMPLE_W-1:0] store [MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (accept && ch_ok) begin
      store[addr_w] <= sample_in;
    end
    if (en1) begin
      rd_a <= store[addr_a];
      rd_b <= store[addr_b];
    end
  end

  // Stage 1 side information travelling with the memory reads.
  logic    ok1, va1, vb1, fa1, fb1;
  sample_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1 <= ch_ok;
      va1 <= va;
      vb1 <= vb;
      fa1 <= fa;
      fb1 <= fb;
      s1  <= sample_in;
    end
  end

  // Stage 1: forward the sample written in the same cycle, zero unwritten entries.
  sample_t               a_val, b_val;
  logic signed [SAMPLE_W:0] diff;

  always_comb begin
    a_val = '0;
    b_val = '0;
    if (ok1 && va1) begin
      a_val = fa1 ? s1 : sample_t'(rd_a);
    end
    if (ok1 && vb1) begin
      b_val = fb1 ? s1 : sample_t'(rd_b);
    end
    diff = (SAMPLE_W + 1)'(b_val) - (SAMPLE_W + 1)'(a_val);
  end

  // Stage 2 registers.
  sample_t                  a2;
  logic signed [SAMPLE_W:0] diff2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      a2    <= a_val;
      diff2 <= diff;
    end
  end

  // Stage 3: fraction times difference.
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PROD_W-1:0] prod3;
  sample_t                  a3;

  assign frac_s = $signed({1'b0, delay_fraction});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      prod3 <= frac_s * diff2;
      a3    <= a2;
    end
  end

  // Output stage: add the floored weighted difference to the first tap.
  logic signed [SUM_W-1:0] sum;

  assign sum = SUM_W'(a3) + prod3[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en_o) begin
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      sample_out <= sum[SAMPLE_W-1:0];
    end
  end

  // Checks on the reducer, pointer update and pipeline holding.
  `MIDL_ASSERT_NEXT(a_red_once, red_busy, !red_busy)
  `MIDL_ASSERT_SAME(a_red_quo, red_busy, quo_back <= BACK_W'(whole_raw))
  `MIDL_ASSERT_SAME(a_red_done, !red_busy, BACK_W'(rem) < BACK_W'(MAX_DELAY))
  `MIDL_ASSERT_NEXT(a_ptr_step, accept && ch_ok, wp[$past(ch_idx)] == $past(w_adv))
  `MIDL_ASSERT_NEXT(a_s3_hold, v3 && !en_o, v3 && $stable(prod3) && $stable(a3))

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for the multichannel interpolated delay line.
// Depends on midl_pkg and multichannel_interpolated_delay_line; it checks every result beat
// against an in-bench predictor of the per-channel stores and the linear interpolation.
`timescale 1ns / 100ps

module tb;
  import midl_pkg::*;

  // Register indexes that the block must ignore.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = {CFG_INDEX_W{1'b1}};

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;
  localparam int      CHAN_TOP   = 2 ** CHAN_W - 1;
  localparam int      IDLE_LIMIT = 2000;
  localparam int      SHOWN_ERRORS = 10;

  // Predicts the interpolated tap for every accepted sample and checks result beats in order.
  class delay_tap_scoreboard;
    bit signed [SAMPLE_W-1:0] taps [DEF_CHANNELS][DEF_MAX_DELAY];
    int                       wr_ptr [DEF_CHANNELS];
    bit [DELAY_W-1:0]         delay_whole;
    bit [FRAC_W-1:0]          delay_fraction;
    sample_t                  expected_taps [$];
    int                       failures;

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DELAY_WHOLE) begin
        delay_whole = data[DELAY_W-1:0];
      end else if (idx == REG_DELAY_FRACTION) begin
        delay_fraction = data[FRAC_W-1:0];
      end
    endfunction

    // Writes the sample, advances the pointer and interpolates between the two read taps.
    function void accept_sample(logic [CHAN_W-1:0] ch, sample_t s);
      int     i1;
      int     i2;
      longint a_v;
      longint b_v;
      longint weight;
      longint prod;
      sample_t tap;
      if (ch >= DEF_CHANNELS) begin
        expected_taps.push_back('0);
        return;
      end
      taps[ch][wr_ptr[ch]] = s;
      wr_ptr[ch] = (wr_ptr[ch] + 1) % DEF_MAX_DELAY;
      i1 = (wr_ptr[ch] + DEF_MAX_DELAY - (int'(delay_whole) % DEF_MAX_DELAY)) % DEF_MAX_DELAY;
      i2 = (i1 + 1) % DEF_MAX_DELAY;
      a_v = longint'(taps[ch][i1]);
      b_v = longint'(taps[ch][i2]);
      weight = longint'(delay_fraction);
      // The arithmetic shift drops the low product bits toward minus infinity.
      prod = weight * (b_v - a_v);
      tap = sample_t'(a_v + (prod >>> FRAC_W));
      expected_taps.push_back(tap);
    endfunction

    function void check_tap(sample_t got);
      sample_t want;
      if (expected_taps.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("result beat with no sample pending: got %0d", got);
        return;
      end
      want = expected_taps.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= SHOWN_ERRORS)
          $display("sample_out mismatch: expected %0d got %0d", want, got);
      end
    endfunction

    function int pending();
      return expected_taps.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic [CHAN_W-1:0]      channel = '0;
  sample_t                sample_in = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  sample_t                sample_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  delay_tap_scoreboard sb;
  bit                  feed_steady = 1'b0;
  bit                  sink_steady = 1'b0;
  int                  idle_cycles = 0;

  multichannel_interpolated_delay_line dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .channel      (channel),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_tap(sample_out);
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multichannel_interpolated_delay_line verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls a random number of cycles before taking each result beat, none while sink_steady.
  initial begin
    int hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
      if ($urandom_range(0, 79) == 0)
        sink_steady = !sink_steady;
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 32)) - 16);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] rand_channel();
    if ($urandom_range(0, 9) == 0)
      return CHAN_W'($urandom_range(DEF_CHANNELS, CHAN_TOP));
    return CHAN_W'($urandom_range(0, DEF_CHANNELS - 1));
  endfunction

  // Sends one sample beat after a random gap; returns at the falling edge after acceptance.
  task automatic send_item(logic [CHAN_W-1:0] ch, sample_t s);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    channel    <= ch;
    sample_in  <= s;
    do @(posedge clk); while (item_stall);
    sb.accept_sample(ch, s);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  // Waits until every predicted result has arrived, checking only after each rising clock edge.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    @(negedge clk);
  endtask

  // Idles the block, then writes both registers, optionally after an ignored index.
  task automatic configure(logic [CFG_DATA_W-1:0] whole_data, logic [FRAC_W-1:0] frac,
                           bit spare);
    drain();
    if (spare)
      write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                CFG_DATA_W'($urandom));
    write_reg(REG_DELAY_WHOLE, whole_data);
    write_reg(REG_DELAY_FRACTION, frac);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // Reset settings: zero delay reads the oldest, still cleared, entry.
    send_item(CHAN_W'(0), SAMPLE_MAX);
    send_item(CHAN_W'(DEF_CHANNELS - 1), SAMPLE_MIN);
    send_item(CHAN_W'(DEF_CHANNELS), SAMPLE_MAX);
    send_item(CHAN_W'(CHAN_TOP), sample_t'(-1));
    send_item(CHAN_W'(3), '0);
    // Delay of one passes the new sample through; the upper data bits are ignored.
    configure(16'hF001, 16'h0000, 1'b1);
    send_item(CHAN_W'(0), SAMPLE_MAX);
    send_item(CHAN_W'(0), SAMPLE_MIN);
    // Full weight between the previous and the current sample, with large swings.
    configure(16'h0002, 16'hFFFF, 1'b0);
    send_item(CHAN_W'(1), SAMPLE_MAX);
    send_item(CHAN_W'(1), SAMPLE_MIN);
    send_item(CHAN_W'(1), SAMPLE_MAX);
    send_item(CHAN_W'(1), SAMPLE_MIN);
    // Half weight, where negative differences round toward minus infinity.
    configure(16'h0002, 16'h8000, 1'b1);
    send_item(CHAN_W'(1), SAMPLE_MIN);
    send_item(CHAN_W'(1), SAMPLE_MAX);
    send_item(CHAN_W'(1), sample_t'(-1));
    send_item(CHAN_W'(1), sample_t'(1));
    // Largest whole delay reaches just past the write pointer.
    configure(16'h0FFF, 16'h0001, 1'b0);
    send_item(CHAN_W'(2), SAMPLE_MAX);
    send_item(CHAN_W'(0), sample_t'(-1));
  endtask

  function automatic logic [DELAY_W-1:0] rand_delay();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DELAY_W'(1);
      2: return DELAY_W'(2);
      3: return DELAY_W'($urandom_range(3, 40));
      4: return '1;
      5: return DELAY_W'($urandom);
      6: return DELAY_W'($urandom_range(1, 8));
      default: return DELAY_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  // Mixed channels under changing settings, a few dozen to a hundred-odd beats per setting.
  task automatic run_random();
    int sent;
    int burst;
    sent = 0;
    while (sent < 1300) begin
      configure({4'($urandom), rand_delay()}, rand_fraction(), $urandom_range(0, 3) == 0);
      feed_steady = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 160);
      repeat (burst) send_item(rand_channel(), rand_sample());
      sent += burst;
    end
    feed_steady = 1'b0;
  endtask

  // One channel takes long bursts under whole delays 0, 1, 4094, 4095 and random ones.
  task automatic run_wrap();
    logic [CHAN_W-1:0] ch;
    int written;
    int burst;
    int step;
    written = 0;
    step = 0;
    while (written < 400) begin
      case (step % 6)
        0: configure(16'h0000, rand_fraction(), 1'b0);
        1: configure(16'h0FFF, 16'hFFFF, 1'b0);
        2: configure(16'h0001, rand_fraction(), 1'b1);
        3: configure({4'($urandom), rand_delay()}, rand_fraction(), 1'b0);
        4: configure(16'h0FFE, 16'h8000, 1'b0);
        default: configure(16'h0000, 16'hFFFF, 1'b0);
      endcase
      feed_steady = ($urandom_range(0, 1) == 0);
      burst = $urandom_range(60, 120);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0) begin
          ch = CHAN_W'($urandom_range(DEF_CHANNELS, CHAN_TOP));
        end else begin
          ch = CHAN_W'(DEF_CHANNELS - 1);
          written++;
        end
        send_item(ch, rand_sample());
      end
      step++;
    end
    feed_steady = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    run_wrap();
    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d predicted results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("multichannel_interpolated_delay_line verification clean");
    else
      $display("multichannel_interpolated_delay_line verification failed");
    $finish;
  end

endmodule
